@@ rtl/stack_machine_integer_alu_defines.svh @@
// Assertion macros shared by the stack machine RTL.
`ifndef STACK_MACHINE_INTEGER_ALU_DEFINES_SVH
`define STACK_MACHINE_INTEGER_ALU_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMIA_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smia assertion failed");

// Next-cycle implication, checked outside reset.
`define SMIA_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smia assertion failed");

`endif

@@ rtl/smia_pkg.sv @@
// Types and constants of the stack machine integer ALU.
package smia_pkg;

    typedef enum logic [4:0] {
        OP_NOP   = 5'd0,
        OP_PUSHI = 5'd1,
        OP_NULL  = 5'd2,
        OP_TRUE  = 5'd3,
        OP_FALSE = 5'd4,
        OP_POP   = 5'd5,
        OP_DUP   = 5'd6,
        OP_DUP2  = 5'd7,
        OP_SWAP  = 5'd8,
        OP_ROT   = 5'd9,
        OP_OVER  = 5'd10,
        OP_ADD   = 5'd11,
        OP_SUB   = 5'd12,
        OP_MUL   = 5'd13,
        OP_DIV   = 5'd14,
        OP_MOD   = 5'd15,
        OP_NEG   = 5'd16,
        OP_ABS   = 5'd17,
        OP_INC   = 5'd18,
        OP_DEC   = 5'd19
    } op_t;

    typedef enum logic [1:0] {
        KIND_NULL = 2'd0,
        KIND_INT  = 2'd1,
        KIND_BOOL = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_DIVZERO   = 3'd3,
        ERR_MODZERO   = 3'd4,
        ERR_TYPE      = 3'd5
    } err_t;

    typedef enum logic [3:0] {
        F_ADD, F_SUB, F_MUL, F_DIV, F_MOD, F_NEG, F_ABS, F_INC, F_DEC
    } alu_func_t;

    typedef struct packed {
        logic      start;
        alu_func_t func;
    } alu_req_t;

    typedef enum logic [2:0] {
        A_IDLE, A_RUN, A_MUL, A_DIV, A_FIX, A_DONE
    } alu_state_t;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_CAPT, S_EVAL, S_ALU, S_PUSH, S_TOP, S_TOPW, S_OUT
    } seq_state_t;

    // push source code 3 selects the computed result, 0..2 an operand slot
    localparam logic [1:0] SRC_RES = 2'd3;
    localparam logic [8:0] LIMIT_RESET = 9'd256;

endpackage

@@ rtl/smia_stack.sv @@
// Operand stack storage: one write port, one registered read port.
module smia_stack
    import smia_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int VW    = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  kind_t         wr_kind,
    input  logic [VW-1:0] wr_value,
    input  logic [AW-1:0] rd_addr,
    output kind_t         rd_kind,
    output logic [VW-1:0] rd_value
);

    logic [VW-1:0] value_mem [DEPTH];
    kind_t         kind_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= wr_value;
            kind_mem[wr_addr]  <= wr_kind;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_value <= value_mem[rd_addr];
        rd_kind  <= kind_mem[rd_addr];
    end

endmodule

@@ rtl/smia_alu.sv @@
// Iterative integer unit: one adder for all ops, incl. shift-add multiply, restoring divide.
module smia_alu
    import smia_pkg::*;
#(
    parameter int VW = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  alu_req_t      req,
    input  logic [VW-1:0] a,
    input  logic [VW-1:0] b,
    output logic          done,
    output logic [VW-1:0] result
);

    localparam int CNTW = $clog2(VW);

    alu_state_t    state_reg, state_next;
    alu_func_t     func_reg, func_next;
    logic [VW-1:0] opa_reg, opa_next;
    logic [VW-1:0] opb_reg, opb_next;
    logic [VW-1:0] res_reg, res_next;
    logic          nega_reg, nega_next;
    logic          negb_reg, negb_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    logic [VW:0]   add_x, add_y;
    logic          add_c;
    logic [VW+1:0] sum;
    logic [VW:0]   shifted;
    logic [VW-1:0] sel;
    logic          do_neg;

    assign sum     = {1'b0, add_x} + {1'b0, add_y} + (VW+2)'(add_c);
    assign shifted = {res_reg, opa_reg[VW-1]};
    assign sel     = (func_reg == F_MOD) ? res_reg : opa_reg;
    assign do_neg  = (func_reg == F_MOD) ? nega_reg : (nega_reg ^ negb_reg);
    assign result  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= A_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        res_reg  <= res_next;
        nega_reg <= nega_next;
        negb_reg <= negb_next;
        cnt_reg  <= cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        res_next   = res_reg;
        nega_next  = nega_reg;
        negb_next  = negb_reg;
        cnt_next   = cnt_reg;
        add_x      = '0;
        add_y      = '0;
        add_c      = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    func_next = req.func;
                    cnt_next  = '0;
                    nega_next = a[VW-1];
                    negb_next = b[VW-1];
                    res_next  = '0;
                    priority case (req.func)
                        F_MUL:
                        begin
                            opa_next   = a;
                            opb_next   = b;
                            state_next = A_MUL;
                        end
                        F_DIV, F_MOD:
                        begin
                            // work on magnitudes, fix signs at the end
                            opa_next   = a[VW-1] ? (~a + 1'b1) : a;
                            opb_next   = b[VW-1] ? (~b + 1'b1) : b;
                            state_next = A_DIV;
                        end
                        default:
                        begin
                            opa_next   = a;
                            opb_next   = b;
                            state_next = A_RUN;
                        end
                    endcase
                end
            end
            A_RUN:
            begin
                unique case (func_reg)
                    F_SUB:
                    begin
                        add_x = {1'b0, opa_reg};
                        add_y = {1'b0, ~opb_reg};
                        add_c = 1'b1;
                    end
                    F_NEG:
                    begin
                        add_y = {1'b0, ~opa_reg};
                        add_c = 1'b1;
                    end
                    F_ABS:
                    begin
                        if (opa_reg[VW-1])
                        begin
                            add_y = {1'b0, ~opa_reg};
                            add_c = 1'b1;
                        end
                        else
                        begin
                            add_x = {1'b0, opa_reg};
                        end
                    end
                    F_INC:
                    begin
                        add_x = {1'b0, opa_reg};
                        add_c = 1'b1;
                    end
                    F_DEC:
                    begin
                        add_x = {1'b0, opa_reg};
                        add_y = {1'b0, {VW{1'b1}}};
                    end
                    default:
                    begin
                        add_x = {1'b0, opa_reg};
                        add_y = {1'b0, opb_reg};
                    end
                endcase
                res_next   = sum[VW-1:0];
                state_next = A_DONE;
            end
            A_MUL:
            begin
                add_x      = {1'b0, res_reg};
                add_y      = opb_reg[0] ? {1'b0, opa_reg} : '0;
                res_next   = sum[VW-1:0];
                opa_next   = {opa_reg[VW-2:0], 1'b0};
                opb_next   = {1'b0, opb_reg[VW-1:1]};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(VW - 1))
                    state_next = A_DONE;
            end
            A_DIV:
            begin
                // trial subtract; carry out set means the divisor fits
                add_x    = shifted;
                add_y    = ~{1'b0, opb_reg};
                add_c    = 1'b1;
                res_next = sum[VW+1] ? sum[VW-1:0] : shifted[VW-1:0];
                opa_next = {opa_reg[VW-2:0], sum[VW+1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(VW - 1))
                    state_next = A_FIX;
            end
            A_FIX:
            begin
                if (do_neg)
                begin
                    add_y = {1'b0, ~sel};
                    add_c = 1'b1;
                end
                else
                begin
                    add_x = {1'b0, sel};
                end
                res_next   = sum[VW-1:0];
                state_next = A_DONE;
            end
            A_DONE:
            begin
                done       = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/stack_machine_integer_alu.sv @@
// Each operation fetches its operands from the stack, evaluates, runs the ALU for arithmetic,
// pushes its results and reads the new top before out_valid; an empty pop or a peek below the
// bottom reads null without a stack read. All ALU functions share one adder.
// Flow: one word in flight; the next is accepted in the cycle after the result loads,
// plus any wait on a stalled result.
// Reset: stack empty, limit 256, no result pending; stack memory is not cleared.
module stack_machine_integer_alu
    import smia_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int VALUE_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  operation,
    input  logic signed [63:0] immediate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [63:0] top_value,
    output logic [1:0]  top_kind,
    output logic [8:0]  depth,
    output logic [2:0]  error_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    `include "stack_machine_integer_alu_defines.svh"

    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    seq_state_t    state_reg, state_next;
    op_t           op_reg, op_next;
    logic [VW-1:0] imm_reg, imm_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [8:0]    lim_reg, lim_next;
    err_t          err_reg, err_next;
    logic [1:0]    fidx_reg, fidx_next;
    logic [1:0]    pidx_reg, pidx_next;
    kind_t         slot_k_reg [3];
    kind_t         slot_k_next [3];
    logic [VW-1:0] slot_v_reg [3];
    logic [VW-1:0] slot_v_next [3];
    kind_t         res_k_reg, res_k_next;
    logic [VW-1:0] res_v_reg, res_v_next;
    kind_t         tk_reg, tk_next;
    logic [VW-1:0] tv_reg, tv_next;
    logic          ov_reg, ov_next;
    kind_t         ok_reg, ok_next;
    logic [VW-1:0] oval_reg, oval_next;
    logic [CW-1:0] od_reg, od_next;
    err_t          oe_reg, oe_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    kind_t         wr_kind, rd_kind;
    logic [VW-1:0] wr_value, rd_value;
    alu_req_t      alu_req;
    logic          alu_done;
    logic [VW-1:0] alu_result;
    logic [VW-1:0] alu_a;

    logic [1:0]    nf, npush, look_d, src;
    logic          is_look, is_bin, is_un, full;
    alu_func_t     func;

    smia_stack #(.DEPTH(STACK_DEPTH), .VW(VW)) u_stack (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_kind  (wr_kind),
        .wr_value (wr_value),
        .rd_addr  (rd_addr),
        .rd_kind  (rd_kind),
        .rd_value (rd_value)
    );

    // unary ops have their only operand in slot 0
    assign alu_a = is_un ? slot_v_reg[0] : slot_v_reg[1];

    smia_alu #(.VW(VW)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (slot_v_reg[0]),
        .done   (alu_done),
        .result (alu_result)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign out_valid  = ov_reg;
    assign top_kind   = ok_reg;
    assign top_value  = 64'($signed(oval_reg));
    assign depth      = 9'(od_reg);
    assign error_code = oe_reg;

    assign full = (32'(cnt_reg) >= 32'(lim_reg)) || (32'(cnt_reg) >= 32'(STACK_DEPTH));

    // per-operation shape: operand fetches, peek or pop, pushes and their sources
    always_comb
    begin
        nf      = 2'd0;
        npush   = 2'd0;
        is_look = 1'b0;
        is_bin  = 1'b0;
        is_un   = 1'b0;
        look_d  = 2'd0;
        src     = SRC_RES;
        func    = F_ADD;
        unique case (op_reg)
            OP_PUSHI, OP_NULL, OP_TRUE, OP_FALSE: npush = 2'd1;
            OP_POP:  nf = 2'd1;
            OP_DUP:
            begin
                nf = 2'd1; npush = 2'd1; is_look = 1'b1; src = 2'd0;
            end
            OP_DUP2:
            begin
                nf = 2'd2; npush = 2'd2; is_look = 1'b1;
                look_d = (fidx_reg == 2'd0) ? 2'd1 : 2'd0;
                src = pidx_reg;
            end
            OP_SWAP:
            begin
                nf = 2'd2; npush = 2'd2; src = pidx_reg;
            end
            OP_ROT:
            begin
                nf = 2'd3; npush = 2'd3;
                src = (pidx_reg == 2'd0) ? 2'd0 : ((pidx_reg == 2'd1) ? 2'd2 : 2'd1);
            end
            OP_OVER:
            begin
                nf = 2'd1; npush = 2'd1; is_look = 1'b1; look_d = 2'd1; src = 2'd0;
            end
            OP_ADD: begin nf = 2'd2; npush = 2'd1; is_bin = 1'b1; func = F_ADD; end
            OP_SUB: begin nf = 2'd2; npush = 2'd1; is_bin = 1'b1; func = F_SUB; end
            OP_MUL: begin nf = 2'd2; npush = 2'd1; is_bin = 1'b1; func = F_MUL; end
            OP_DIV: begin nf = 2'd2; npush = 2'd1; is_bin = 1'b1; func = F_DIV; end
            OP_MOD: begin nf = 2'd2; npush = 2'd1; is_bin = 1'b1; func = F_MOD; end
            OP_NEG: begin nf = 2'd1; npush = 2'd1; is_un = 1'b1; func = F_NEG; end
            OP_ABS: begin nf = 2'd1; npush = 2'd1; is_un = 1'b1; func = F_ABS; end
            OP_INC: begin nf = 2'd1; npush = 2'd1; is_un = 1'b1; func = F_INC; end
            OP_DEC: begin nf = 2'd1; npush = 2'd1; is_un = 1'b1; func = F_DEC; end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            lim_reg   <= LIMIT_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lim_reg   <= lim_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        imm_reg    <= imm_next;
        err_reg    <= err_next;
        fidx_reg   <= fidx_next;
        pidx_reg   <= pidx_next;
        slot_k_reg <= slot_k_next;
        slot_v_reg <= slot_v_next;
        res_k_reg  <= res_k_next;
        res_v_reg  <= res_v_next;
        tk_reg     <= tk_next;
        tv_reg     <= tv_next;
        ok_reg     <= ok_next;
        oval_reg   <= oval_next;
        od_reg     <= od_next;
        oe_reg     <= oe_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        imm_next    = imm_reg;
        cnt_next    = cnt_reg;
        lim_next    = lim_reg;
        err_next    = err_reg;
        fidx_next   = fidx_reg;
        pidx_next   = pidx_reg;
        slot_k_next = slot_k_reg;
        slot_v_next = slot_v_reg;
        res_k_next  = res_k_reg;
        res_v_next  = res_v_reg;
        tk_next     = tk_reg;
        tv_next     = tv_reg;
        ok_next     = ok_reg;
        oval_next   = oval_reg;
        od_next     = od_reg;
        oe_next     = oe_reg;
        ov_next     = ov_reg && out_stall;
        wr_en       = 1'b0;
        wr_addr     = AW'(cnt_reg);
        wr_kind     = KIND_NULL;
        wr_value    = '0;
        rd_addr     = AW'(cnt_reg - 1'b1);
        alu_req     = '{start: 1'b0, func: func};

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                    lim_next = cfg_data;
                if (in_valid)
                begin
                    op_next    = op_t'(operation);
                    imm_next   = immediate[VW-1:0];
                    err_next   = ERR_NONE;
                    fidx_next  = 2'd0;
                    pidx_next  = 2'd0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (fidx_reg == nf)
                begin
                    state_next = S_EVAL;
                end
                else if (is_look)
                begin
                    if (32'(look_d) >= 32'(cnt_reg))
                    begin
                        // peek below the bottom reads null
                        slot_k_next[fidx_reg] = KIND_NULL;
                        slot_v_next[fidx_reg] = '0;
                        fidx_next = fidx_reg + 2'd1;
                    end
                    else
                    begin
                        rd_addr    = AW'(cnt_reg - 1'b1 - CW'(look_d));
                        state_next = S_CAPT;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    slot_k_next[fidx_reg] = KIND_NULL;
                    slot_v_next[fidx_reg] = '0;
                    if (err_reg == ERR_NONE)
                        err_next = ERR_UNDERFLOW;
                    fidx_next = fidx_reg + 2'd1;
                end
                else
                begin
                    rd_addr    = AW'(cnt_reg - 1'b1);
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_CAPT;
                end
            end
            S_CAPT:
            begin
                slot_k_next[fidx_reg] = rd_kind;
                slot_v_next[fidx_reg] = rd_value;
                fidx_next  = fidx_reg + 2'd1;
                state_next = S_FETCH;
            end
            S_EVAL:
            begin
                state_next = S_PUSH;
                res_k_next = KIND_NULL;
                res_v_next = '0;
                priority case (1'b1)
                    is_bin:
                    begin
                        // divide-by-zero wins over the type check, modulo checks types first
                        if (op_reg == OP_DIV && slot_k_reg[0] == KIND_INT &&
                            slot_v_reg[0] == '0)
                        begin
                            if (err_reg == ERR_NONE)
                                err_next = ERR_DIVZERO;
                        end
                        else if (slot_k_reg[0] != KIND_INT || slot_k_reg[1] != KIND_INT)
                        begin
                            if (err_reg == ERR_NONE)
                                err_next = ERR_TYPE;
                        end
                        else if (op_reg == OP_MOD && slot_v_reg[0] == '0)
                        begin
                            if (err_reg == ERR_NONE)
                                err_next = ERR_MODZERO;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            state_next    = S_ALU;
                        end
                    end
                    is_un:
                    begin
                        if (slot_k_reg[0] != KIND_INT)
                        begin
                            if (err_reg == ERR_NONE)
                                err_next = ERR_TYPE;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            state_next    = S_ALU;
                        end
                    end
                    default:
                    begin
                        priority case (op_reg)
                            OP_PUSHI: begin res_k_next = KIND_INT;  res_v_next = imm_reg; end
                            OP_TRUE:  begin res_k_next = KIND_BOOL; res_v_next = VW'(1); end
                            OP_FALSE: res_k_next = KIND_BOOL;
                            default: ;
                        endcase
                    end
                endcase
            end
            S_ALU:
            begin
                if (alu_done)
                begin
                    res_k_next = KIND_INT;
                    res_v_next = alu_result;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (pidx_reg == npush)
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    if (src == SRC_RES)
                    begin
                        wr_kind  = res_k_reg;
                        wr_value = res_v_reg;
                    end
                    else
                    begin
                        wr_kind  = slot_k_reg[src];
                        wr_value = slot_v_reg[src];
                    end
                    if (wr_kind == KIND_NULL)
                        wr_value = '0;
                    if (full)
                    begin
                        if (err_reg == ERR_NONE)
                            err_next = ERR_OVERFLOW;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    pidx_next = pidx_reg + 2'd1;
                end
            end
            S_TOP:
            begin
                if (cnt_reg == '0)
                begin
                    tk_next    = KIND_NULL;
                    tv_next    = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    rd_addr    = AW'(cnt_reg - 1'b1);
                    state_next = S_TOPW;
                end
            end
            S_TOPW:
            begin
                tk_next    = rd_kind;
                tv_next    = rd_value;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ok_next    = tk_reg;
                    oval_next  = tv_reg;
                    od_next    = cnt_reg;
                    oe_next    = err_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SMIA_IMPLIES(a_count_bound, 1'b1, 32'(cnt_reg) <= 32'(STACK_DEPTH))
    `SMIA_IMPLIES(a_write_room, wr_en, !full)
    `SMIA_NEXT(a_push_counts, wr_en, cnt_reg == $past(cnt_reg) + 1'b1)
    `SMIA_NEXT(a_first_error_kept, state_reg != S_IDLE && err_reg != ERR_NONE,
               err_reg == $past(err_reg))

endmodule
